### rtl/process_tick_scheduler_macros.svh
// Assertion helpers for the tick scheduler.
`ifndef PROCESS_TICK_SCHEDULER_MACROS_SVH
`define PROCESS_TICK_SCHEDULER_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PTS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define PTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/pts_pkg.sv
package pts_pkg;
    localparam int MaxEntries = 16;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_HEAD   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_PRIO = 2'd1;
    localparam logic [1:0] POL_SRTF = 2'd2;

    localparam logic [1:0] REG_POLICY = 2'd0;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [7:0]  run;
        logic [15:0] arrival;
    } t_cmd;
endpackage

### rtl/pts_front.sv
module pts_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [1:0]      i_operation,
    input  logic [7:0]      i_process_id,
    input  logic [7:0]      i_priority_req,
    input  logic [7:0]      i_run_time,
    input  logic [15:0]     i_arrival_time,
    input  logic            i_take,
    output logic            o_busy,
    output logic            o_valid,
    output pts_pkg::t_cmd   o_cmd
);
    // Two-entry queue of classified commands; unknown operations are dropped here.
    pts_pkg::t_cmd r_q [2];
    logic          r_rd, r_wr;
    logic [1:0]    r_cnt;
    logic          w_acc, w_push, w_pop;

    assign o_busy  = (r_cnt == 2'd2);
    assign w_acc   = i_start && !o_busy;
    assign w_push  = w_acc && (i_operation != pts_pkg::OP_UNUSED);
    assign w_pop   = i_take && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{op: i_operation, id: i_process_id, prio: i_priority_req,
                           run: i_run_time, arrival: i_arrival_time};
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= !r_wr;
            if (w_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

### rtl/pts_back.sv
module pts_back #(
    parameter int MAX_ENTRIES = pts_pkg::MaxEntries
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pts_pkg::t_cmd   i_cmd,
    input  logic [1:0]      i_policy,
    output logic            o_take,
    output logic            o_idle_all,
    output logic            o_strobe,
    output logic [7:0]      o_chosen_id,
    output logic            o_idle
);
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int NP = 1 << IW;

    // Slot registers form a shift line so head inserts move every entry at once.
    logic [7:0]  r_id   [MAX_ENTRIES];
    logic [7:0]  r_prio [MAX_ENTRIES];
    logic [7:0]  r_rem  [MAX_ENTRIES];
    logic [15:0] r_arr  [MAX_ENTRIES];
    logic [CW-1:0] r_count;
    logic [15:0]   r_time;
    logic [IW-1:0] r_fslot;
    logic          r_fvalid;

    typedef enum logic {S_TAKE, S_APPLY} t_state;
    t_state        r_state;
    pts_pkg::t_cmd r_cmd;

    // Selection: a tournament tree in which the left, earlier side wins ties.
    logic [MAX_ENTRIES-1:0] w_rdy;
    logic          w_tv   [2*NP];
    logic [7:0]    w_tkey [2*NP];
    logic [IW-1:0] w_tidx [2*NP];
    logic          n_found;
    logic [IW-1:0] n_pick;
    logic          w_factive;
    logic          w_full, w_isfcfs;

    assign w_full   = (r_count == CW'(MAX_ENTRIES));
    assign w_isfcfs = (i_policy != pts_pkg::POL_PRIO) && (i_policy != pts_pkg::POL_SRTF);

    always_comb begin
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            w_rdy[k] = (CW'(k) < r_count) && (r_arr[k] <= r_time) && (r_rem[k] != 8'd0);
        end
        w_factive = r_fvalid && w_rdy[r_fslot];
        for (int k = 0; k < 2 * NP; k++) begin
            w_tv[k]   = 1'b0;
            w_tkey[k] = '0;
            w_tidx[k] = '0;
        end
        // Shortest remaining is turned into a largest key by inverting it.
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            w_tv[NP + k]   = w_rdy[k];
            w_tidx[NP + k] = IW'(k);
            if (i_policy == pts_pkg::POL_PRIO) begin
                w_tkey[NP + k] = r_prio[k];
            end else if (i_policy == pts_pkg::POL_SRTF) begin
                w_tkey[NP + k] = ~r_rem[k];
            end else begin
                w_tkey[NP + k] = 8'd0;
            end
        end
        for (int n = NP - 1; n > 0; n--) begin
            if (w_tv[2*n+1] && (!w_tv[2*n] || w_tkey[2*n+1] > w_tkey[2*n])) begin
                w_tv[n]   = 1'b1;
                w_tkey[n] = w_tkey[2*n+1];
                w_tidx[n] = w_tidx[2*n+1];
            end else begin
                w_tv[n]   = w_tv[2*n];
                w_tkey[n] = w_tkey[2*n];
                w_tidx[n] = w_tidx[2*n];
            end
        end
        n_found = w_tv[1];
        n_pick  = (w_isfcfs && w_factive) ? r_fslot : w_tidx[1];
    end

    assign o_take     = (r_state == S_TAKE);
    assign o_idle_all = (r_state == S_TAKE) && !i_valid;

    always_ff @(posedge i_clk) begin
        if (r_state == S_TAKE && i_valid) begin
            r_cmd <= i_cmd;
        end
        // Slot writes are taken in the apply state.
        if (r_state == S_APPLY && r_cmd.op != pts_pkg::OP_TICK && !w_full) begin
            if (r_cmd.op == pts_pkg::OP_HEAD) begin
                for (int k = MAX_ENTRIES - 1; k > 0; k--) begin
                    r_id[k]   <= r_id[k-1];
                    r_prio[k] <= r_prio[k-1];
                    r_rem[k]  <= r_rem[k-1];
                    r_arr[k]  <= r_arr[k-1];
                end
                r_id[0] <= r_cmd.id; r_prio[0] <= r_cmd.prio;
                r_rem[0] <= r_cmd.run; r_arr[0] <= r_cmd.arrival;
            end else begin
                r_id[r_count[IW-1:0]]   <= r_cmd.id;
                r_prio[r_count[IW-1:0]] <= r_cmd.prio;
                r_rem[r_count[IW-1:0]]  <= r_cmd.run;
                r_arr[r_count[IW-1:0]]  <= r_cmd.arrival;
            end
        end
        if (r_state == S_APPLY && r_cmd.op == pts_pkg::OP_TICK && n_found) begin
            r_rem[n_pick] <= r_rem[n_pick] - 8'd1;
        end
        if (!i_rst_n) begin
            r_state  <= S_TAKE;
            r_count  <= '0;
            r_time   <= '0;
            r_fslot  <= '0;
            r_fvalid <= 1'b0;
            o_strobe <= 1'b0;
            o_chosen_id <= '0;
            o_idle   <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_TAKE: begin
                    if (i_valid) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_state <= S_TAKE;
                    if (r_cmd.op != pts_pkg::OP_TICK) begin
                        if (!w_full) begin
                            r_count <= r_count + CW'(1);
                            if (r_cmd.op == pts_pkg::OP_HEAD && r_fvalid) begin
                                r_fslot <= r_fslot + IW'(1);
                            end
                        end
                    end else begin
                        o_strobe    <= 1'b1;
                        o_chosen_id <= n_found ? r_id[n_pick] : 8'd0;
                        o_idle      <= !n_found;
                        if (r_time != 16'hFFFF) r_time <= r_time + 16'd1;
                        if (w_isfcfs) begin
                            r_fslot  <= n_pick;
                            r_fvalid <= n_found && (r_rem[n_pick] != 8'd1);
                        end else begin
                            r_fvalid <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_TAKE;
            endcase
        end
    end
endmodule

### rtl/process_tick_scheduler.sv
// A tick's strobe is registered in the apply state; inserts give none.
// The back end applies each command before it takes the next.
// A two-entry command queue lets start be taken while the back end works.
// Reset (synchronous, active low) empties the table, clears time and the policy.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "process_tick_scheduler_macros.svh"
module process_tick_scheduler #(
    parameter int MAX_ENTRIES = pts_pkg::MaxEntries
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_process_id,
    input  logic [7:0]  i_priority_req,
    input  logic [7:0]  i_run_time,
    input  logic [15:0] i_arrival_time,
    output logic        o_strobe,
    output logic [7:0]  o_chosen_id,
    output logic        o_idle,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic          w_valid, w_take, w_idle_all;
    pts_pkg::t_cmd w_cmd;
    logic [1:0]    r_policy;

    assign pready = 1'b1;
    assign prdata = (paddr == pts_pkg::REG_POLICY) ? {30'd0, r_policy} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= pts_pkg::POL_FCFS;
        end else if (psel && penable && pwrite && paddr == pts_pkg::REG_POLICY) begin
            r_policy <= pwdata[1:0];
        end
    end

    pts_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_operation, .i_process_id,
        .i_priority_req, .i_run_time, .i_arrival_time,
        .i_take(w_take), .o_busy(busy), .o_valid(w_valid), .o_cmd(w_cmd)
    );

    pts_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_valid), .i_cmd(w_cmd), .i_policy(r_policy),
        .o_take(w_take), .o_idle_all(w_idle_all), .o_strobe, .o_chosen_id, .o_idle
    );

    `PTS_ASSERT_IMP(a_idle_id_zero, o_strobe && o_idle, o_chosen_id == 8'd0)
    `PTS_ASSERT_NEXT(a_no_back_strobe, o_strobe, !o_strobe)
    `PTS_ASSERT_IMP(a_idle_no_strobe_pending, w_idle_all && !w_valid, !busy)
endmodule

### tb/tb_top.sv
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Slots = pts_pkg::MaxEntries;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [7:0]  i_process_id;
    logic [7:0]  i_priority_req;
    logic [7:0]  i_run_time;
    logic [15:0] i_arrival_time;
    logic        o_strobe;
    logic [7:0]  o_chosen_id;
    logic        o_idle;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    process_tick_scheduler dut (.*);

    typedef struct {
        logic [7:0] id;
        logic       idle;
    } t_pick;

    pts_pkg::t_cmd cmd_queue[$];
    t_pick         pick_queue[$];
    int            error_count;
    int            send_idle_pct;
    int            clock_guess;

    // Scheduler state mirrored from the block's behavior.
    logic [7:0]  tbl_id[Slots];
    logic [7:0]  tbl_prio[Slots];
    logic [7:0]  tbl_left[Slots];
    logic [15:0] tbl_arr[Slots];
    int          tbl_count;
    logic [15:0] clock_now;
    int          serve_slot;
    bit          serve_valid;
    logic [1:0]  policy;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic bit slot_ready(int k);
        return tbl_arr[k] <= clock_now && tbl_left[k] != 8'd0;
    endfunction

    // Applies one accepted command and queues the tick outcome, if any.
    function automatic void schedule_cmd(pts_pkg::t_cmd c);
        int pick;
        bit found;
        int pos;
        pick = 0;
        found = 0;
        if (c.op == pts_pkg::OP_APPEND || c.op == pts_pkg::OP_HEAD) begin
            if (tbl_count >= Slots) return;
            pos = tbl_count;
            if (c.op == pts_pkg::OP_HEAD) begin
                for (int k = tbl_count; k > 0; k--) begin
                    tbl_id[k] = tbl_id[k-1];
                    tbl_prio[k] = tbl_prio[k-1];
                    tbl_left[k] = tbl_left[k-1];
                    tbl_arr[k] = tbl_arr[k-1];
                end
                pos = 0;
                if (serve_valid) serve_slot++;
            end
            tbl_id[pos] = c.id;
            tbl_prio[pos] = c.prio;
            tbl_left[pos] = c.run;
            tbl_arr[pos] = c.arrival;
            tbl_count++;
            return;
        end
        if (c.op != pts_pkg::OP_TICK) return;
        if (policy == pts_pkg::POL_PRIO || policy == pts_pkg::POL_SRTF) begin
            serve_valid = 0;
            for (int k = 0; k < tbl_count; k++) begin
                if (!slot_ready(k)) continue;
                if (!found) begin
                    pick = k;
                    found = 1;
                end else if (policy == pts_pkg::POL_PRIO) begin
                    if (tbl_prio[k] > tbl_prio[pick]) pick = k;
                end else if (tbl_left[k] < tbl_left[pick]) begin
                    pick = k;
                end
            end
        end else begin
            if (serve_valid && serve_slot < tbl_count && slot_ready(serve_slot)) begin
                pick = serve_slot;
                found = 1;
            end else begin
                for (int k = 0; k < tbl_count; k++) begin
                    if (slot_ready(k)) begin
                        pick = k;
                        found = 1;
                        break;
                    end
                end
            end
            serve_valid = found;
            serve_slot = pick;
        end
        if (found) begin
            pick_queue.push_back('{tbl_id[pick], 1'b0});
            tbl_left[pick] = tbl_left[pick] - 8'd1;
            if (tbl_left[pick] == 8'd0 && serve_valid && serve_slot == pick) serve_valid = 0;
        end else begin
            pick_queue.push_back('{8'd0, 1'b1});
        end
        if (clock_now != 16'hFFFF) clock_now++;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic pts_pkg::t_cmd cmd_head();
        return cmd_queue.pop_front();
    endfunction

    // Driver: start stays high across back-to-back transfers.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) schedule_cmd(cmd_head());
            if ((!start || !busy) && cmd_queue.size() > 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                start <= 1'b1;
                i_operation <= cmd_queue[0].op;
                i_process_id <= cmd_queue[0].id;
                i_priority_req <= cmd_queue[0].prio;
                i_run_time <= cmd_queue[0].run;
                i_arrival_time <= cmd_queue[0].arrival;
            end else if (start && !busy) begin
                start <= 1'b0;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pick_queue.size() == 0) begin
                report_mismatch("unexpected result, chosen_id", o_chosen_id, -1);
            end else begin
                t_pick p;
                p = pick_queue.pop_front();
                if (o_chosen_id !== p.id) report_mismatch("chosen_id", o_chosen_id, p.id);
                if (o_idle !== p.idle) report_mismatch("idle", o_idle, p.idle);
            end
        end
    end

    task automatic write_policy(logic [1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= pts_pkg::REG_POLICY;
        pwdata <= 32'(value) | ($urandom() & 32'hFFFF_FFFC);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        policy = value;
    endtask

    task automatic drain();
        while (cmd_queue.size() > 0 || start || pick_queue.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic pts_pkg::t_cmd rand_cmd(int tick_pct);
        pts_pkg::t_cmd c;
        int r;
        r = $urandom_range(99);
        c.op = r < tick_pct ? pts_pkg::OP_TICK :
               (r < tick_pct + 4 ? pts_pkg::OP_UNUSED :
               ($urandom_range(1) ? pts_pkg::OP_HEAD : pts_pkg::OP_APPEND));
        c.id = 8'($urandom());
        c.prio = 8'($urandom());
        c.run = $urandom_range(9) == 0 ? 8'($urandom()) : 8'($urandom_range(1, 6));
        // Arrivals mostly near the present so entries become ready.
        c.arrival = $urandom_range(19) == 0 ? 16'($urandom()) :
                    16'(clock_guess + $urandom_range(0, 8));
        if (c.op == pts_pkg::OP_TICK) clock_guess++;
        return c;
    endfunction

    task automatic add_cmd(logic [1:0] op, int id, int prio, int run, int arr);
        pts_pkg::t_cmd c;
        c.op = op;
        c.id = 8'(id);
        c.prio = 8'(prio);
        c.run = 8'(run);
        c.arrival = 16'(arr);
        cmd_queue.push_back(c);
        if (op == pts_pkg::OP_TICK) clock_guess++;
    endtask

    initial begin
        start = 1'b0;
        i_operation = '0;
        i_process_id = '0;
        i_priority_req = '0;
        i_run_time = '0;
        i_arrival_time = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        send_idle_pct = 26;
        tbl_count = 0;
        clock_now = '0;
        serve_slot = 0;
        serve_valid = 0;
        policy = pts_pkg::POL_FCFS;
        clock_guess = 0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tick, extremes, head insert during first-come service,
        // finished entries, future arrivals and the unused operation code.
        add_cmd(pts_pkg::OP_TICK, 0, 0, 0, 0);
        add_cmd(pts_pkg::OP_APPEND, 8'hFF, 8'hFF, 3, 0);
        add_cmd(pts_pkg::OP_APPEND, 0, 0, 0, 0);
        add_cmd(pts_pkg::OP_TICK, 0, 0, 0, 0);
        add_cmd(pts_pkg::OP_HEAD, 8'h55, 8'hAA, 8'hFF, 16'hFFFF);
        add_cmd(pts_pkg::OP_HEAD, 8'hAA, 8'h55, 1, 1);
        add_cmd(pts_pkg::OP_TICK, 0, 0, 0, 0);
        add_cmd(pts_pkg::OP_TICK, 0, 0, 0, 0);
        add_cmd(pts_pkg::OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
        add_cmd(pts_pkg::OP_TICK, 0, 0, 0, 0);
        add_cmd(pts_pkg::OP_APPEND, 7, 9, 2, 4);
        repeat (4) add_cmd(pts_pkg::OP_TICK, 0, 0, 0, 0);
        drain();

        for (int phase = 0; phase < 9; phase++) begin
            write_policy(phase == 8 ? 2'd3 : 2'(phase % 3));
            send_idle_pct = phase < 3 ? 26 : (phase < 6 ? 79 : 0);
            // Refill toward a full table so the drop path is exercised too.
            for (int n = 0; n < 160; n++) cmd_queue.push_back(rand_cmd(55));
            drain();
        end

        // One closing tick under shortest-remaining service.
        write_policy(pts_pkg::POL_SRTF);
        add_cmd(pts_pkg::OP_TICK, 0, 0, 0, 0);
        drain();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_front.sv
rtl/pts_back.sv
rtl/process_tick_scheduler.sv
tb/tb_top.sv
